FILE: sv/u8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

   // Byte classes
   localparam logic [1:0] CLS_ASCII = 2'd0;
   localparam logic [1:0] CLS_CONT  = 2'd1;
   localparam logic [1:0] CLS_LEAD  = 2'd2;
   localparam logic [1:0] CLS_BAD   = 2'd3;

   // Error kinds
   localparam logic ERR_BAD_LEAD = 1'b0;
   localparam logic ERR_BROKEN   = 1'b1;

   // Class queue between front and back
   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Result queue
   localparam logic [1:0] RQ_DEPTH = 2'd2;

   typedef struct packed {
      logic [1:0] cls;
      logic [2:0] count;   // continuation bytes a lead opens
      logic [6:0] pay;     // payload bits of the byte
      logic [7:0] raw;
   } cls_rec_type;

   typedef struct packed {
      logic        empty;
      logic        full;
   } cq_status_type;

   typedef struct packed {
      logic [2:0]  rem;
      logic        part_zero;
   } bk_status_type;

   typedef struct packed {
      logic [30:0] value;
      logic        err;
      logic        kind;
      logic        last;
   } res_type;

endpackage

FILE: sv/u8d_front.sv
// Front end: classifies each raw byte and extracts its payload bits.
module u8d_front (
   input  logic [7:0]          in_byte,
   output u8d_pkg::cls_rec_type rec
);
   import u8d_pkg::*;

   always_comb begin
      rec.raw   = in_byte;
      rec.cls   = CLS_BAD;
      rec.count = 3'd0;
      rec.pay   = 7'd0;
      case (in_byte) inside
         8'b0???????: begin
            rec.cls = CLS_ASCII;
            rec.pay = in_byte[6:0];
         end
         8'b10??????: begin
            rec.cls = CLS_CONT;
            rec.pay = {1'b0, in_byte[5:0]};
         end
         8'b110?????: begin
            rec.cls   = CLS_LEAD;
            rec.count = 3'd1;
            rec.pay   = {2'b00, in_byte[4:0]};
         end
         8'b1110????: begin
            rec.cls   = CLS_LEAD;
            rec.count = 3'd2;
            rec.pay   = {3'b000, in_byte[3:0]};
         end
         8'b11110???: begin
            rec.cls   = CLS_LEAD;
            rec.count = 3'd3;
            rec.pay   = {4'b0000, in_byte[2:0]};
         end
         8'b111110??: begin
            rec.cls   = CLS_LEAD;
            rec.count = 3'd4;
            rec.pay   = {5'b00000, in_byte[1:0]};
         end
         8'b1111110?: begin
            rec.cls   = CLS_LEAD;
            rec.count = 3'd5;
            rec.pay   = {6'b000000, in_byte[0]};
         end
         default: begin
            rec.cls = CLS_BAD;   // 0xFE, 0xFF
         end
      endcase
   end

endmodule

FILE: sv/u8d_cls_fifo.sv
// Short queue of classified bytes between front and back.
module u8d_cls_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8d_pkg::cls_rec_type   rec_in,
   input  logic                   pop,
   output u8d_pkg::cls_rec_type   rec_out,
   output u8d_pkg::cq_status_type status
);
   import u8d_pkg::*;

   cls_rec_type         mem [CQ_DEPTH];
   logic [CQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == CQ_CNT_W'(CQ_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rec_out      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= rec_in;
      end
   end

endmodule

FILE: sv/u8d_back.sv
// Back end: sequence state, result generation and the result queue.
module u8d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  u8d_pkg::cls_rec_type   rec,
   input  logic                   rec_valid,
   output logic                   rec_take,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output u8d_pkg::res_type       rsp,
   output u8d_pkg::bk_status_type status
);
   import u8d_pkg::*;

   logic [2:0]  rem_ff, rem_in;
   logic [30:0] part_ff, part_in;
   logic [30:0] part_shift;
   res_type     res;
   logic        wr;

   res_type     rq_mem [2];
   logic        rq_wr_ff, rq_wr_in;
   logic        rq_rd_ff, rq_rd_in;
   logic [1:0]  rq_cnt_ff, rq_cnt_in;
   logic        pop_ok, space;

   assign pop_ok     = rsp_pop && (rq_cnt_ff != 2'd0);
   assign space      = (rq_cnt_ff != RQ_DEPTH) || pop_ok;
   assign part_shift = {part_ff[24:0], rec.pay[5:0]};

   always_comb begin
      rem_in   = rem_ff;
      part_in  = part_ff;
      rec_take = 1'b0;
      wr       = 1'b0;
      res      = '0;
      if (rec_valid && space) begin
         if (rem_ff == 3'd0) begin
            rec_take = 1'b1;
            case (rec.cls)
               CLS_ASCII: begin
                  wr        = 1'b1;
                  res.value = {24'd0, rec.pay};
                  res.last  = 1'b1;
               end
               CLS_LEAD: begin
                  rem_in  = rec.count;
                  part_in = {24'd0, rec.pay};
               end
               default: begin
                  wr        = 1'b1;
                  res.value = {23'd0, rec.raw};
                  res.err   = 1'b1;
                  res.kind  = ERR_BAD_LEAD;
                  res.last  = 1'b1;
               end
            endcase
         end else if (rec.cls == CLS_CONT) begin
            rec_take = 1'b1;
            rem_in   = rem_ff - 1'b1;
            if (rem_ff == 3'd1) begin
               wr        = 1'b1;
               res.value = part_shift;
               res.last  = 1'b1;
               part_in   = '0;
            end else begin
               part_in = part_shift;
            end
         end else begin
            // broken sequence: report, drop the partial value, keep the byte to replay it as a lead
            wr        = 1'b1;
            res.value = part_ff;
            res.err   = 1'b1;
            res.kind  = ERR_BROKEN;
            res.last  = (rec.cls == CLS_LEAD);
            rem_in    = 3'd0;
            part_in   = '0;
         end
      end
   end

   always_comb begin
      rq_wr_in  = wr     ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in  = pop_ok ? ~rq_rd_ff : rq_rd_ff;
      case ({wr, pop_ok})
         2'b10:   rq_cnt_in = rq_cnt_ff + 1'b1;
         2'b01:   rq_cnt_in = rq_cnt_ff - 1'b1;
         default: rq_cnt_in = rq_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         part_ff   <= '0;
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= '0;
      end else begin
         rem_ff    <= rem_in;
         part_ff   <= part_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         rq_mem[rq_wr_ff] <= res;
      end
   end

   assign rsp_empty        = (rq_cnt_ff == 2'd0);
   assign rsp              = rq_mem[rq_rd_ff];
   assign status.rem       = rem_ff;
   assign status.part_zero = (part_ff == '0);

endmodule

FILE: sv/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder (legacy 5- and 6-byte forms included).
//
// Usage:
//   Input is a queue write port: drive req_in_byte and raise req_push; the
//   beat is taken at a clock edge where req_full is low. Results come out of
//   a queue read port: while rsp_empty is low the oldest result sits on the
//   rsp_ fields, and raising rsp_pop takes it at the next edge.
//   Each result carries a 31-bit value, an error flag, an error kind (invalid
//   lead or broken sequence) and last_of_run, set on the final result a byte
//   causes. A lead byte that opens a sequence gives no result.
// Path: the back end decodes the byte that completes a result while it is the
//   class queue head, and registers the result into the result queue, whose
//   head sits on the rsp_ ports.
// Throughput: one byte per cycle while the result queue has room. A byte that
//   breaks a sequence holds the back end, as it is handled again as a lead
//   byte; the front keeps taking beats meanwhile until the class queue fills.
// Stall: when rsp_pop stays low, the two-entry result queue and then the
//   four-entry class queue fill, and req_full rises; nothing is dropped.
// Reset (reset, synchronous, active high) empties both queues and closes any
//   open sequence.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [30:0] rsp_code_value,
   output logic        rsp_is_error,
   output logic        rsp_error_kind,
   output logic        rsp_last_of_run
);
   import u8d_pkg::*;

   cls_rec_type   front_rec;
   cls_rec_type   head_rec;
   cq_status_type cq_status;
   bk_status_type bk_status;
   logic          head_take;
   res_type       rsp;

   // classify the incoming byte
   u8d_front u_front (
      .in_byte (req_in_byte),
      .rec     (front_rec)
   );

   // decouples the byte side from the result side
   u8d_cls_fifo u_cls_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .rec_in  (front_rec),
      .pop     (head_take),
      .rec_out (head_rec),
      .status  (cq_status)
   );

   // decode state and result queue
   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec       (head_rec),
      .rec_valid (!cq_status.empty),
      .rec_take  (head_take),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp),
      .status    (bk_status)
   );

   assign req_full        = cq_status.full;
   assign rsp_code_value  = rsp.value;
   assign rsp_is_error    = rsp.err;
   assign rsp_error_kind  = rsp.kind;
   assign rsp_last_of_run = rsp.last;

   // no open sequence means no leftover partial value
   a_idle_part_clear: assert property (@(posedge clock) disable iff (reset)
      (bk_status.rem == 3'd0) |-> bk_status.part_zero)
      else $error("partial value left with no sequence open");

   // the longest lead opens five continuation bytes
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      bk_status.rem <= 3'd5)
      else $error("continuation count out of range");

   // a broken-sequence kind only appears on error results
   a_kind_err: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error_kind) |-> rsp_is_error)
      else $error("error kind set on a non-error result");

   // the back end takes nothing from an empty class queue
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      head_take |-> !cq_status.empty)
      else $error("class queue popped while empty");

endmodule

FILE: verif/tb_utf8_stream_decoder.sv
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

// Tracks the open sequence and the code points the decoder owes.
class decode_scoreboard;
   logic [2:0]        cont_left;
   logic [30:0]       acc_value;
   u8d_pkg::res_type  owed_codes[$];
   int                mismatch_count;

   function new();
      cont_left      = '0;
      acc_value      = '0;
      mismatch_count = 0;
   endfunction

   // Byte seen with no sequence open. Returns 1 when it yields a result.
   function bit open_or_flag(logic [7:0] b, output u8d_pkg::res_type r);
      r = '0;
      case (b) inside
         8'b0???????: begin
            r.value = {23'd0, b};
            return 1'b1;
         end
         8'b110?????: begin
            cont_left = 3'd1;
            acc_value = {26'd0, b[4:0]};
         end
         8'b1110????: begin
            cont_left = 3'd2;
            acc_value = {27'd0, b[3:0]};
         end
         8'b11110???: begin
            cont_left = 3'd3;
            acc_value = {28'd0, b[2:0]};
         end
         8'b111110??: begin
            cont_left = 3'd4;
            acc_value = {29'd0, b[1:0]};
         end
         8'b1111110?: begin
            cont_left = 3'd5;
            acc_value = {30'd0, b[0]};
         end
         default: begin
            r.value = {23'd0, b};
            r.err   = 1'b1;
            r.kind  = u8d_pkg::ERR_BAD_LEAD;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function void note_byte(logic [7:0] b);
      u8d_pkg::res_type outs[2];
      u8d_pkg::res_type r;
      int      n;
      n = 0;
      if (cont_left == 3'd0) begin
         if (open_or_flag(b, r)) begin
            outs[0] = r;
            n = 1;
         end
      end else if (b[7:6] == 2'b10) begin
         acc_value = {acc_value[24:0], b[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 3'd0) begin
            outs[0]       = '0;
            outs[0].value = acc_value;
            acc_value     = '0;
            n = 1;
         end
      end else begin
         // sequence broken: flag the partial value, then retry b as a lead
         outs[0]       = '0;
         outs[0].value = acc_value;
         outs[0].err   = 1'b1;
         outs[0].kind  = u8d_pkg::ERR_BROKEN;
         cont_left     = '0;
         acc_value     = '0;
         n = 1;
         if (open_or_flag(b, r)) begin
            outs[1] = r;
            n = 2;
         end
      end
      for (int i = 0; i < n; i++) begin
         outs[i].last = (i == n - 1);
         owed_codes.push_back(outs[i]);
      end
   endfunction

   task report(string msg);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task check_result(logic [30:0] v, logic e, logic k, logic l);
      u8d_pkg::res_type want;
      if (owed_codes.size() == 0) begin
         report($sformatf("unexpected beat value=%h err=%b kind=%b last=%b", v, e, k, l));
      end else begin
         want = owed_codes.pop_front();
         if (v !== want.value)
            report($sformatf("code_value %h, want %h", v, want.value));
         if (e !== want.err)
            report($sformatf("is_error %b, want %b", e, want.err));
         if (k !== want.kind)
            report($sformatf("error_kind %b, want %b", k, want.kind));
         if (l !== want.last)
            report($sformatf("last_of_run %b, want %b", l, want.last));
      end
   endtask

   function int owed();
      return owed_codes.size();
   endfunction
endclass

module tb_utf8_stream_decoder;

   localparam int ITEM_TARGET = 1100;
   localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
   localparam int DRAIN_TAIL  = 8;        // margin after the last owed result

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [30:0] rsp_code_value;
   logic        rsp_is_error;
   logic        rsp_error_kind;
   logic        rsp_last_of_run;

   decode_scoreboard sb = new();

   int          cycle_count = 0;
   int          beats_sent = 0;
   int          burst_left = 0;

   // receiver stall pattern, rotated one bit per cycle, re-drawn when pop_phase % 64 is zero
   logic [15:0] pop_pattern = 16'hFFFF;
   int          pop_phase = 0;

   // Directed opening: ASCII extremes, invalid leads, one two-byte and one
   // three-byte sequence, the all-ones six-byte form, and breaks that end in ASCII, in an
   // invalid lead and in a new lead that then completes.
   logic [7:0] opening_bytes [24] = '{
      8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
      8'hC2, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
      8'hE2, 8'h41,
      8'hF0, 8'h9F, 8'hFF,
      8'hF8, 8'hC3, 8'hA9
   };

   utf8_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_value  (rsp_code_value),
      .rsp_is_error    (rsp_is_error),
      .rsp_error_kind  (rsp_error_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver. Outputs are read right after the edge, so they still hold the
   // values the edge saw; a pop then is a completed beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            sb.check_result(rsp_code_value, rsp_is_error, rsp_error_kind, rsp_last_of_run);
         pop_phase++;
         if (pop_phase % 64 == 0) begin
            case ($urandom_range(0, 3))
               0:       pop_pattern = 16'hFFFF;                       // no stalls
               1:       pop_pattern = 16'($urandom());                // scattered stalls
               2:       pop_pattern = 16'($urandom() & $urandom());   // heavy stalls
               default: pop_pattern = 16'h8001;                       // long stalls
            endcase
            if (pop_pattern == 16'h0000)
               pop_pattern = 16'h0001;
         end else begin
            pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
         end
         rsp_pop <= pop_pattern[0];
      end
   end

   // One beat on the input side. Bursts of random length are separated by
   // random gaps; a gap of zero keeps push high straight into the next burst.
   // Called just after an edge; returns just after the accepting edge.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      sb.note_byte(b);
      beats_sent++;
      burst_left--;
   endtask

   // A sequence of total_len bytes with random payload. When cut is set the
   // sequence is interrupted by a random byte that is not a continuation.
   task automatic send_sequence(input int total_len, input bit cut);
      logic [7:0] lead;
      logic [7:0] breaker;
      int         conts;
      lead = 8'($urandom());
      case (total_len)
         1:       lead = {1'b0, lead[6:0]};
         2:       lead = {3'b110, lead[4:0]};
         3:       lead = {4'b1110, lead[3:0]};
         4:       lead = {5'b11110, lead[2:0]};
         5:       lead = {6'b111110, lead[1:0]};
         default: lead = {7'b1111110, lead[0]};
      endcase
      conts = cut ? $urandom_range(0, total_len - 2) : total_len - 1;
      push_byte(lead);
      for (int i = 0; i < conts; i++)
         push_byte({2'b10, 6'($urandom())});
      if (cut) begin
         do breaker = 8'($urandom()); while (breaker[7:6] == 2'b10);
         push_byte(breaker);
      end
   endtask

   // Hold the sender off until every owed result has come out.
   task automatic drain_pause();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.owed() > 0);
   endtask

   initial begin
      int next_drain;
      int pick;
      next_drain = 450;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i])
         push_byte(opening_bytes[i]);

      // Mostly well-formed sequences with random payload; the rest are cut
      // sequences and raw noise bytes.
      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent >= next_drain) begin
            drain_pause();
            next_drain += 450;
         end
         pick = $urandom_range(0, 19);
         if (pick < 14)
            send_sequence($urandom_range(1, 6), 1'b0);
         else if (pick < 17)
            send_sequence($urandom_range(2, 6), 1'b1);
         else
            push_byte(8'($urandom_range(0, 255)));
      end

      req_push <= 1'b0;
      do @(posedge clock); while (sb.owed() > 0);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.owed() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: utf8_stream_decoder.f
sv/u8d_pkg.sv
sv/u8d_front.sv
sv/u8d_cls_fifo.sv
sv/u8d_back.sv
sv/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
